@@ hdl/ihc_pkg.sv @@
package ihc_pkg;

   // Fixed header and protocol limits.
   localparam int unsigned HdrMinBytes = 20;
   localparam logic [15:0] CsumGood    = 16'hFFFF;

   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 32;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_HOST_ADDR      = 3'd0,
      CSR_SUBNET_MASK    = 3'd1,
      CSR_CSUM_OFFLOADED = 3'd2,
      CSR_PROTO_SLOT_A   = 3'd3,
      CSR_PROTO_SLOT_B   = 3'd4
   } ihc_csr_idx_type;

   typedef enum logic [2:0] {
      VERDICT_SHORT      = 3'd0,
      VERDICT_BAD_CSUM   = 3'd1,
      VERDICT_TRUNCATED  = 3'd2,
      VERDICT_TOO_BIG    = 3'd3,
      VERDICT_NOT_OURS   = 3'd4,
      VERDICT_REASSEMBLE = 3'd5,
      VERDICT_DELIVER    = 3'd6,
      VERDICT_NO_PROTO   = 3'd7
   } ihc_verdict_type;

   localparam logic [7:0] ProtoSlotAReset = 8'd6;
   localparam logic [7:0] ProtoSlotBReset = 8'd1;

   typedef struct packed {
      logic [15:0] ver_ihl_tos;
      logic [15:0] total_len;
      logic [15:0] ident;
      logic [15:0] flags_frag;
      logic [15:0] ttl_proto;
      logic [15:0] hdr_csum;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] buffer_len;
      logic        was_reassembled;
   } ihc_req_type;

   typedef struct packed {
      ihc_verdict_type verdict;
      logic            learn_neighbor;
      logic [15:0]     trim_bytes;
      logic [5:0]      header_bytes;
      logic [15:0]     frag_offset_bytes;
   } ihc_rsp_type;

   typedef struct packed {
      logic [31:0] host_addr;
      logic [31:0] subnet_mask;
      logic        csum_offloaded;
      logic [7:0]  proto_slot_a;
      logic [7:0]  proto_slot_b;
   } ihc_cfg_type;

endpackage

@@ hdl/ihc_if.sv @@
interface ihc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] ver_ihl_tos;
   logic [15:0] total_len;
   logic [15:0] ident;
   logic [15:0] flags_frag;
   logic [15:0] ttl_proto;
   logic [15:0] hdr_csum;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [15:0] buffer_len;
   logic        was_reassembled;

   modport source (output valid, output ver_ihl_tos, output total_len, output ident,
                   output flags_frag, output ttl_proto, output hdr_csum, output src_addr,
                   output dst_addr, output buffer_len, output was_reassembled,
                   input ready);
   modport sink (input valid, input ver_ihl_tos, input total_len, input ident,
                 input flags_frag, input ttl_proto, input hdr_csum, input src_addr,
                 input dst_addr, input buffer_len, input was_reassembled,
                 output ready);
endinterface

interface ihc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  verdict;
   logic        learn_neighbor;
   logic [15:0] trim_bytes;
   logic [5:0]  header_bytes;
   logic [15:0] frag_offset_bytes;

   modport source (output valid, output verdict, output learn_neighbor,
                   output trim_bytes, output header_bytes, output frag_offset_bytes,
                   input ready);
   modport sink (input valid, input verdict, input learn_neighbor,
                 input trim_bytes, input header_bytes, input frag_offset_bytes,
                 output ready);
endinterface

interface ihc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/ihc_classify.sv @@
module ihc_classify import ihc_pkg::*; (
   input  ihc_req_type hdr,
   input  ihc_cfg_type cfg,
   output ihc_rsp_type res
);

   logic [19:0] csum_sum;
   logic [16:0] csum_fold1;
   logic [16:0] csum_fold2;
   logic        csum_ok;
   logic [15:0] offset_bytes;
   logic [16:0] end_bytes;
   logic        frag_mf;
   logic [7:0]  proto;

   // Ones' complement sum of the ten header words, folded twice.
   always_comb begin
      csum_sum = 20'(hdr.ver_ihl_tos) + 20'(hdr.total_len) + 20'(hdr.ident)
               + 20'(hdr.flags_frag) + 20'(hdr.ttl_proto) + 20'(hdr.hdr_csum)
               + 20'(hdr.src_addr[31:16]) + 20'(hdr.src_addr[15:0])
               + 20'(hdr.dst_addr[31:16]) + 20'(hdr.dst_addr[15:0]);
      csum_fold1 = 17'(csum_sum[15:0]) + 17'(csum_sum[19:16]);
      csum_fold2 = 17'(csum_fold1[15:0]) + 17'(csum_fold1[16]);
      csum_ok    = cfg.csum_offloaded || hdr.was_reassembled ||
                   (csum_fold2[15:0] == CsumGood);
   end

   assign offset_bytes = {hdr.flags_frag[12:0], 3'b000};
   assign end_bytes    = 17'(offset_bytes) + 17'(hdr.total_len);
   assign frag_mf      = hdr.flags_frag[13];
   assign proto        = hdr.ttl_proto[7:0];

   always_comb begin
      res.header_bytes      = {hdr.ver_ihl_tos[11:8], 2'b00};
      res.frag_offset_bytes = offset_bytes;
      res.learn_neighbor    = 1'b0;
      res.trim_bytes        = '0;
      if (hdr.buffer_len < 16'(HdrMinBytes)) begin
         res.verdict = VERDICT_SHORT;
      end else if (!csum_ok) begin
         res.verdict = VERDICT_BAD_CSUM;
      end else if (hdr.total_len > hdr.buffer_len) begin
         res.verdict = VERDICT_TRUNCATED;
      end else begin
         res.trim_bytes = hdr.buffer_len - hdr.total_len;
         if (end_bytes[16]) begin
            res.verdict = VERDICT_TOO_BIG;
         end else begin
            res.learn_neighbor = (((hdr.src_addr ^ cfg.host_addr) & cfg.subnet_mask) == '0)
                                 && (hdr.src_addr != cfg.host_addr);
            if (hdr.dst_addr != cfg.host_addr) begin
               res.verdict = VERDICT_NOT_OURS;
            end else if (frag_mf || (offset_bytes != '0)) begin
               res.verdict = VERDICT_REASSEMBLE;
            end else if ((proto == cfg.proto_slot_a) || (proto == cfg.proto_slot_b)) begin
               res.verdict = VERDICT_DELIVER;
            end else begin
               res.verdict = VERDICT_NO_PROTO;
            end
         end
      end
   end

endmodule

@@ hdl/ipv4_rx_header_classifier_top.sv @@
// Channel  Direction  Carries
// req_ch   in         one decoded IPv4 header, buffer length, reassembled flag
// rsp_ch   out        verdict, neighbor hint, trim count, header and offset bytes
// csr_ch   in         register index and write data
//
// Each header transaction passes an input register and then an output register
// on its way to rsp_ch.
// One header is accepted every cycle while rsp_ch is ready; the rate is set by the single classify
// stage between the two registers, which holds no state across headers.
// A stalled rsp_ch holds its result; one more header can still be taken into
// the input register before req_ch.ready drops.
// Reset is synchronous and active high; it empties both stages and loads the
// register reset values. csr_ch is always ready and takes effect next cycle.
module ipv4_rx_header_classifier_top import ihc_pkg::*; (
   input logic       clock,
   input logic       reset,
   ihc_req_if.sink   req_ch,
   ihc_rsp_if.source rsp_ch,
   ihc_csr_if.sink   csr_ch
);

   ihc_cfg_type cfg_ff;
   ihc_cfg_type cfg_in;

   logic        s1_valid_ff;
   logic        s1_valid_in;
   ihc_req_type s1_data_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   ihc_rsp_type out_data_ff;
   ihc_rsp_type class_res;
   logic        out_adv;
   logic        s1_adv;

   // Configuration writes: unknown indexes are dropped.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (ihc_csr_idx_type'(csr_ch.index))
            CSR_HOST_ADDR:      cfg_in.host_addr      = csr_ch.data;
            CSR_SUBNET_MASK:    cfg_in.subnet_mask    = csr_ch.data;
            CSR_CSUM_OFFLOADED: cfg_in.csum_offloaded = csr_ch.data[0];
            CSR_PROTO_SLOT_A:   cfg_in.proto_slot_a   = csr_ch.data[7:0];
            CSR_PROTO_SLOT_B:   cfg_in.proto_slot_b   = csr_ch.data[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.host_addr      <= '0;
         cfg_ff.subnet_mask    <= '0;
         cfg_ff.csum_offloaded <= 1'b0;
         cfg_ff.proto_slot_a   <= ProtoSlotAReset;
         cfg_ff.proto_slot_b   <= ProtoSlotBReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The output register moves when it is empty or its result is taken; the
   // input register moves when it is empty or can hand its header onward.
   assign out_adv      = !out_valid_ff || rsp_ch.ready;
   assign s1_adv       = !s1_valid_ff || out_adv;
   assign req_ch.ready = s1_adv;

   always_comb begin
      s1_valid_in  = s1_adv ? req_ch.valid : s1_valid_ff;
      out_valid_in = out_adv ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && req_ch.valid) begin
         s1_data_ff.ver_ihl_tos     <= req_ch.ver_ihl_tos;
         s1_data_ff.total_len       <= req_ch.total_len;
         s1_data_ff.ident           <= req_ch.ident;
         s1_data_ff.flags_frag      <= req_ch.flags_frag;
         s1_data_ff.ttl_proto       <= req_ch.ttl_proto;
         s1_data_ff.hdr_csum        <= req_ch.hdr_csum;
         s1_data_ff.src_addr        <= req_ch.src_addr;
         s1_data_ff.dst_addr        <= req_ch.dst_addr;
         s1_data_ff.buffer_len      <= req_ch.buffer_len;
         s1_data_ff.was_reassembled <= req_ch.was_reassembled;
      end
      if (out_adv && s1_valid_ff) begin
         out_data_ff <= class_res;
      end
   end

   // All checks for one header sit in this single combinational stage.
   ihc_classify u_classify (
      .hdr (s1_data_ff),
      .cfg (cfg_ff),
      .res (class_res)
   );

   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.verdict           = out_data_ff.verdict;
   assign rsp_ch.learn_neighbor    = out_data_ff.learn_neighbor;
   assign rsp_ch.trim_bytes        = out_data_ff.trim_bytes;
   assign rsp_ch.header_bytes      = out_data_ff.header_bytes;
   assign rsp_ch.frag_offset_bytes = out_data_ff.frag_offset_bytes;

endmodule

@@ hdl/ihc_checker.sv @@
module ihc_checker import ihc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_verdict,
   input logic        rsp_learn,
   input logic [15:0] rsp_trim,
   input logic [5:0]  rsp_hdr_bytes,
   input logic [15:0] rsp_off_bytes
);

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result transaction dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_verdict) && $stable(rsp_trim)
                                  && $stable(rsp_learn))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_early_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict == VERDICT_SHORT || rsp_verdict == VERDICT_BAD_CSUM
                    || rsp_verdict == VERDICT_TRUNCATED)
      |-> !rsp_learn && (rsp_trim == '0))
      else $error("early drop carries learn or trim");

   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hdr_bytes[1:0] == 2'b00) && (rsp_off_bytes[2:0] == 3'b000)
                    && !(rsp_learn && rsp_verdict == VERDICT_TOO_BIG))
      else $error("misaligned byte counts or learn on oversize drop");

endmodule

bind ipv4_rx_header_classifier_top ihc_checker u_ihc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_verdict   (rsp_ch.verdict),
   .rsp_learn     (rsp_ch.learn_neighbor),
   .rsp_trim      (rsp_ch.trim_bytes),
   .rsp_hdr_bytes (rsp_ch.header_bytes),
   .rsp_off_bytes (rsp_ch.frag_offset_bytes)
);

@@ verif/ipv4_verdict_checker.sv @@
`timescale 1ns / 1ps

module ipv4_verdict_checker import ihc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ihc_req_if          req_mon,
   ihc_rsp_if          rsp_mon,
   ihc_csr_if          csr_mon,
   output int unsigned mismatch_count,
   output int unsigned verdicts_pending
);

   localparam logic [16:0] IpLenMax  = 17'h0FFFF;
   localparam int unsigned ShownMax  = 10;

   ihc_cfg_type cfg_shadow;
   ihc_rsp_type verdicts_expected[$];
   int unsigned fault_total = 0;

   assign mismatch_count = fault_total;

   // Ones' complement sum of the ten header words, folded to 16 bits.
   function automatic logic [15:0] header_ones_sum(input ihc_req_type h);
      logic [31:0] acc;
      acc = 32'(h.ver_ihl_tos) + 32'(h.total_len) + 32'(h.ident) + 32'(h.flags_frag)
          + 32'(h.ttl_proto) + 32'(h.hdr_csum) + 32'(h.src_addr[31:16])
          + 32'(h.src_addr[15:0]) + 32'(h.dst_addr[31:16]) + 32'(h.dst_addr[15:0]);
      acc = 32'(acc[15:0]) + 32'(acc[31:16]);
      acc = 32'(acc[15:0]) + 32'(acc[31:16]);
      return acc[15:0];
   endfunction

   function automatic ihc_rsp_type classify_header(input ihc_req_type h,
                                                   input ihc_cfg_type c);
      ihc_rsp_type r;
      logic [16:0] span;
      r.verdict           = VERDICT_SHORT;
      r.learn_neighbor    = 1'b0;
      r.trim_bytes        = '0;
      r.header_bytes      = {h.ver_ihl_tos[11:8], 2'b00};
      r.frag_offset_bytes = {h.flags_frag[12:0], 3'b000};
      span = {1'b0, r.frag_offset_bytes} + {1'b0, h.total_len};
      if (h.buffer_len < 16'(HdrMinBytes)) begin
         r.verdict = VERDICT_SHORT;
      end else if (!c.csum_offloaded && !h.was_reassembled &&
                   header_ones_sum(h) != CsumGood) begin
         r.verdict = VERDICT_BAD_CSUM;
      end else if (h.total_len > h.buffer_len) begin
         r.verdict = VERDICT_TRUNCATED;
      end else begin
         r.trim_bytes = h.buffer_len - h.total_len;
         if (span > IpLenMax) begin
            r.verdict = VERDICT_TOO_BIG;
         end else begin
            r.learn_neighbor = (((h.src_addr ^ c.host_addr) & c.subnet_mask) == '0) &&
                               (h.src_addr != c.host_addr);
            if (h.dst_addr != c.host_addr) begin
               r.verdict = VERDICT_NOT_OURS;
            end else if (h.flags_frag[13] || r.frag_offset_bytes != '0) begin
               r.verdict = VERDICT_REASSEMBLE;
            end else if (h.ttl_proto[7:0] == c.proto_slot_a ||
                         h.ttl_proto[7:0] == c.proto_slot_b) begin
               r.verdict = VERDICT_DELIVER;
            end else begin
               r.verdict = VERDICT_NO_PROTO;
            end
         end
      end
      return r;
   endfunction

   task automatic note_fault(input string what, input logic [31:0] want,
                             input logic [31:0] got);
      fault_total++;
      if (fault_total <= ShownMax) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      ihc_req_type seen_hdr;
      ihc_rsp_type want;
      if (reset) begin
         cfg_shadow.host_addr      <= '0;
         cfg_shadow.subnet_mask    <= '0;
         cfg_shadow.csum_offloaded <= 1'b0;
         cfg_shadow.proto_slot_a   <= ProtoSlotAReset;
         cfg_shadow.proto_slot_b   <= ProtoSlotBReset;
         verdicts_expected.delete();
         verdicts_pending <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            seen_hdr.ver_ihl_tos     = req_mon.ver_ihl_tos;
            seen_hdr.total_len       = req_mon.total_len;
            seen_hdr.ident           = req_mon.ident;
            seen_hdr.flags_frag      = req_mon.flags_frag;
            seen_hdr.ttl_proto       = req_mon.ttl_proto;
            seen_hdr.hdr_csum        = req_mon.hdr_csum;
            seen_hdr.src_addr        = req_mon.src_addr;
            seen_hdr.dst_addr        = req_mon.dst_addr;
            seen_hdr.buffer_len      = req_mon.buffer_len;
            seen_hdr.was_reassembled = req_mon.was_reassembled;
            verdicts_expected.insert(verdicts_expected.size(),
                                     classify_header(seen_hdr, cfg_shadow));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (verdicts_expected.size() == 0) begin
               note_fault("unexpected result transaction", '0, 32'(rsp_mon.verdict));
            end else begin
               want = verdicts_expected[0];
               verdicts_expected.delete(0);
               if (rsp_mon.verdict !== want.verdict)
                  note_fault("verdict", 32'(want.verdict), 32'(rsp_mon.verdict));
               if (rsp_mon.learn_neighbor !== want.learn_neighbor)
                  note_fault("learn_neighbor", 32'(want.learn_neighbor),
                             32'(rsp_mon.learn_neighbor));
               if (rsp_mon.trim_bytes !== want.trim_bytes)
                  note_fault("trim_bytes", 32'(want.trim_bytes), 32'(rsp_mon.trim_bytes));
               if (rsp_mon.header_bytes !== want.header_bytes)
                  note_fault("header_bytes", 32'(want.header_bytes),
                             32'(rsp_mon.header_bytes));
               if (rsp_mon.frag_offset_bytes !== want.frag_offset_bytes)
                  note_fault("frag_offset_bytes", 32'(want.frag_offset_bytes),
                             32'(rsp_mon.frag_offset_bytes));
            end
         end
         verdicts_pending <= verdicts_expected.size();
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_HOST_ADDR:      cfg_shadow.host_addr      <= csr_mon.data;
               CSR_SUBNET_MASK:    cfg_shadow.subnet_mask    <= csr_mon.data;
               CSR_CSUM_OFFLOADED: cfg_shadow.csum_offloaded <= csr_mon.data[0];
               CSR_PROTO_SLOT_A:   cfg_shadow.proto_slot_a   <= csr_mon.data[7:0];
               CSR_PROTO_SLOT_B:   cfg_shadow.proto_slot_b   <= csr_mon.data[7:0];
               default: ;
            endcase
         end
      end
   end

endmodule

@@ verif/tb_ipv4_rx_header_classifier_top.sv @@
`timescale 1ns / 1ps

// Top of the header classifier testbench. This module only creates stimulus
// (headers, register writes and result-side back pressure) and reports the
// verdict. All prediction and comparison happen in the checker instance,
// which watches the three channels and hands back a mismatch count and the
// number of results still outstanding.
module tb_ipv4_rx_header_classifier_top;
   import ihc_pkg::*;

   localparam int unsigned ResetCycles    = 8;
   localparam int unsigned DrainCycles    = 8;
   localparam int unsigned WatchdogLimit  = 5000;
   localparam int unsigned PhaseCount     = 6;
   localparam int unsigned PhaseItems     = 125;
   localparam int unsigned PressureAt     = 60;
   localparam int unsigned CsrFirstUnused = int'(CSR_PROTO_SLOT_B) + 1;
   localparam int unsigned CsrSlotCount   = 1 << CsrIdxW;

   // Bits of the flags and fragment offset word.
   localparam logic [15:0] FlagDontFrag  = 16'h4000;
   localparam logic [15:0] FlagMoreFrags = 16'h2000;
   localparam logic [15:0] OffsetMask    = 16'h1FFF;

   logic clock = 1'b0;
   logic reset;

   // Stalls and gaps are only inserted while this is set, so that some
   // phases run at full rate on both sides.
   bit stalls_on;
   int rsp_hold = 0;
   int unsigned idle_cycles = 0;
   int unsigned mismatch_count;
   int unsigned verdicts_pending;

   // The register values the block should hold right now; the stimulus uses
   // them to aim headers at the host and at the attached subnet.
   ihc_cfg_type active_cfg;

   ihc_req_if req_ch ();
   ihc_rsp_if rsp_ch ();
   ihc_csr_if csr_ch ();

   ipv4_rx_header_classifier_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   ipv4_verdict_checker verdict_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .csr_mon          (csr_ch),
      .mismatch_count   (mismatch_count),
      .verdicts_pending (verdicts_pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Most gaps are short; roughly one in ten is long enough to let the
   // pipeline fill or drain completely.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Result-side back pressure; each stall is sized by the picked gap.
   // The ready is unknown until the first edge, which falls inside reset.
   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ch.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 99) < 25) begin
         rsp_hold <= pick_gap();
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // The watchdog counts cycles in which no transaction completes on any
   // channel. A hung handshake ends the run here.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Returns the header with its checksum field set so that the whole
   // header sums to all ones.
   function automatic ihc_req_type seal_header(input ihc_req_type h);
      logic [31:0] acc;
      h.hdr_csum = '0;
      acc = h.ver_ihl_tos + h.total_len + h.ident + h.flags_frag + h.ttl_proto
          + h.src_addr[31:16] + h.src_addr[15:0] + h.dst_addr[31:16] + h.dst_addr[15:0];
      acc = acc[15:0] + acc[31:16];
      acc = acc[15:0] + acc[31:16];
      h.hdr_csum = ~acc[15:0];
      return h;
   endfunction

   // A plain 60-byte datagram for the host, from an address off the subnet
   // used by the directed part, carrying the first registered protocol.
   function automatic ihc_req_type base_header();
      ihc_req_type h;
      h.ver_ihl_tos     = 16'h4500;
      h.total_len       = 16'd60;
      h.ident           = 16'($urandom);
      h.flags_frag      = FlagDontFrag;
      h.ttl_proto       = {8'd64, active_cfg.proto_slot_a};
      h.hdr_csum        = '0;
      h.src_addr        = 32'hAC10_0001;
      h.dst_addr        = active_cfg.host_addr;
      h.buffer_len      = 16'd60;
      h.was_reassembled = 1'b0;
      return h;
   endfunction

   // Random headers. A minority is pure noise; the rest is mostly well-formed
   // traffic for this host so that the later checks are reached, with a few
   // short buffers, truncations, fragments and bad checksums mixed in.
   function automatic ihc_req_type random_header();
      ihc_req_type h;
      int unsigned extra;
      int unsigned stretch;
      h.ident = 16'($urandom);
      if ($urandom_range(0, 99) < 15) begin
         h.ver_ihl_tos     = 16'($urandom);
         h.total_len       = 16'($urandom);
         h.flags_frag      = 16'($urandom);
         h.ttl_proto       = 16'($urandom);
         h.hdr_csum        = 16'($urandom);
         h.src_addr        = $urandom;
         h.dst_addr        = $urandom;
         h.buffer_len      = 16'($urandom);
         h.was_reassembled = 1'($urandom);
         return h;
      end
      h.ver_ihl_tos = {4'h4, 4'($urandom_range(5, 15)), 8'($urandom)};
      if ($urandom_range(0, 9) == 0) h.ver_ihl_tos = 16'($urandom);
      h.total_len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(20, 1500));
      case ($urandom_range(0, 9))
         0: h.buffer_len = 16'($urandom_range(0, 19));
         1: h.buffer_len = 16'($urandom);
         2: h.buffer_len = 16'hFFFF;
         default: begin
            extra = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200) : 0;
            stretch = h.total_len + extra;
            h.buffer_len = (stretch > 16'hFFFF) ? 16'hFFFF : 16'(stretch);
         end
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2:    h.flags_frag = '0;
         3, 4, 5:    h.flags_frag = FlagDontFrag;
         6, 7:       h.flags_frag = FlagMoreFrags | 16'($urandom_range(0, 200));
         8:          h.flags_frag = 16'($urandom);
         default:    h.flags_frag = 16'($urandom_range(1, OffsetMask));
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3: h.ttl_proto = {8'($urandom), active_cfg.proto_slot_a};
         4, 5, 6:    h.ttl_proto = {8'($urandom), active_cfg.proto_slot_b};
         default:    h.ttl_proto = 16'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3: h.src_addr = (active_cfg.host_addr & active_cfg.subnet_mask) |
                                  ($urandom & ~active_cfg.subnet_mask);
         4:          h.src_addr = active_cfg.host_addr;
         default:    h.src_addr = $urandom;
      endcase
      case ($urandom_range(0, 9))
         8:       h.dst_addr = active_cfg.host_addr ^ (32'd1 << $urandom_range(0, 31));
         9:       h.dst_addr = $urandom;
         default: h.dst_addr = active_cfg.host_addr;
      endcase
      h.was_reassembled = ($urandom_range(0, 9) == 0);
      h = seal_header(h);
      if ($urandom_range(0, 9) == 0) h.hdr_csum = 16'($urandom);
      return h;
   endfunction

   function automatic ihc_cfg_type random_config();
      ihc_cfg_type c;
      int unsigned prefix;
      prefix = $urandom_range(0, 32);
      c.host_addr      = $urandom;
      c.subnet_mask    = ($urandom_range(0, 4) == 0) ? $urandom : (32'hFFFF_FFFF << (32 - prefix));
      c.csum_offloaded = 1'($urandom);
      c.proto_slot_a   = 8'($urandom);
      c.proto_slot_b   = 8'($urandom);
      return c;
   endfunction

   // Offers one header transaction after an optional gap and returns once it
   // has been accepted. The valid is only lowered when a gap is taken, so
   // back-to-back headers keep it high.
   task automatic send_header(input ihc_req_type h);
      int gap;
      gap = stalls_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.ver_ihl_tos     <= h.ver_ihl_tos;
      req_ch.total_len       <= h.total_len;
      req_ch.ident           <= h.ident;
      req_ch.flags_frag      <= h.flags_frag;
      req_ch.ttl_proto       <= h.ttl_proto;
      req_ch.hdr_csum        <= h.hdr_csum;
      req_ch.src_addr        <= h.src_addr;
      req_ch.dst_addr        <= h.dst_addr;
      req_ch.buffer_len      <= h.buffer_len;
      req_ch.was_reassembled <= h.was_reassembled;
      req_ch.valid           <= 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // Holds off the sender until every outstanding result has been taken.
   // The first edge lets the count catch up with the last accepted header.
   task automatic wait_all_verdicts();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (verdicts_pending != 0);
   endtask

   task automatic csr_put(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
   endtask

   // Writes all five registers back to back while the block is idle. The
   // narrow registers get random upper bits, which the block must drop.
   // Optionally the unused indexes are written too; those must be ignored.
   task automatic write_config(input ihc_cfg_type c, input bit poke_unused);
      int unsigned k;
      wait_all_verdicts();
      csr_put(CSR_HOST_ADDR, c.host_addr);
      csr_put(CSR_SUBNET_MASK, c.subnet_mask);
      csr_put(CSR_CSUM_OFFLOADED, {31'($urandom), c.csum_offloaded});
      csr_put(CSR_PROTO_SLOT_A, {24'($urandom), c.proto_slot_a});
      csr_put(CSR_PROTO_SLOT_B, {24'($urandom), c.proto_slot_b});
      if (poke_unused) begin
         for (k = CsrFirstUnused; k < CsrSlotCount; k++) csr_put(CsrIdxW'(k), $urandom);
      end
      csr_ch.valid <= 1'b0;
      active_cfg = c;
   endtask

   initial begin
      ihc_req_type h;
      ihc_cfg_type c;
      int unsigned phase;
      int unsigned n;

      // Every input of the block but rsp_ch.ready starts at a known value.
      reset                  <= 1'b1;
      stalls_on              <= 1'b0;
      req_ch.valid           <= 1'b0;
      req_ch.ver_ihl_tos     <= '0;
      req_ch.total_len       <= '0;
      req_ch.ident           <= '0;
      req_ch.flags_frag      <= '0;
      req_ch.ttl_proto       <= '0;
      req_ch.hdr_csum        <= '0;
      req_ch.src_addr        <= '0;
      req_ch.dst_addr        <= '0;
      req_ch.buffer_len      <= '0;
      req_ch.was_reassembled <= 1'b0;
      csr_ch.valid           <= 1'b0;
      csr_ch.index           <= '0;
      csr_ch.data            <= '0;
      active_cfg.host_addr      = '0;
      active_cfg.subnet_mask    = '0;
      active_cfg.csum_offloaded = 1'b0;
      active_cfg.proto_slot_a   = ProtoSlotAReset;
      active_cfg.proto_slot_b   = ProtoSlotBReset;

      repeat (ResetCycles) @(posedge clock);
      reset     <= 1'b0;
      stalls_on <= 1'b1;

      // Two headers under the reset register values: both default protocol
      // slots must deliver.
      send_header(seal_header(base_header()));
      h = base_header();
      h.ttl_proto[7:0] = active_cfg.proto_slot_b;
      send_header(seal_header(h));

      // Directed part: a /24 subnet, checksum checked in this block.
      c.host_addr      = 32'hC0A8_0A05;
      c.subnet_mask    = 32'hFFFF_FF00;
      c.csum_offloaded = 1'b0;
      c.proto_slot_a   = 8'd6;
      c.proto_slot_b   = 8'd17;
      write_config(c, 1'b0);

      // A buffer too short for any header, first empty with all-ones
      // everywhere else, then one byte short of the minimum.
      h.ver_ihl_tos = '1; h.total_len = '1; h.ident = '1; h.flags_frag = '1;
      h.ttl_proto = '1; h.hdr_csum = '1; h.src_addr = '1; h.dst_addr = '1;
      h.buffer_len = '0; h.was_reassembled = 1'b1;
      send_header(h);
      h = base_header(); h.buffer_len = 16'd19; h.total_len = 16'd19;
      send_header(seal_header(h));
      // Exactly the minimum header with nothing behind it.
      h = base_header(); h.buffer_len = 16'd20; h.total_len = 16'd20;
      send_header(seal_header(h));
      // A corrupted checksum, then the same corruption on a reassembled
      // datagram, where the check is skipped.
      h = seal_header(base_header()); h.hdr_csum ^= 16'h0001;
      send_header(h);
      h.was_reassembled = 1'b1;
      send_header(h);
      // Total length one byte past the buffer, then a padded buffer to trim.
      h = base_header(); h.total_len = 16'd61;
      send_header(seal_header(h));
      h = base_header(); h.buffer_len = 16'd1514;
      send_header(seal_header(h));
      // Largest offset: one header too big, one ending exactly at the limit.
      h = base_header(); h.flags_frag = OffsetMask; h.total_len = 16'd20; h.buffer_len = 16'd20;
      send_header(seal_header(h));
      h.total_len = 16'd7;
      send_header(seal_header(h));
      // Neighbor learning: on-subnet source for us, on-subnet source for
      // someone else, and the host's own address as source.
      h = base_header(); h.src_addr = c.host_addr ^ 32'h0000_0033;
      send_header(seal_header(h));
      h.dst_addr = c.host_addr + 1;
      send_header(seal_header(h));
      h = base_header(); h.src_addr = c.host_addr;
      send_header(seal_header(h));
      // Off-subnet source and a foreign destination.
      h = base_header(); h.dst_addr = 32'h0A00_0001;
      send_header(seal_header(h));
      // More-fragments with zero offset goes to reassembly.
      h = base_header(); h.flags_frag = FlagMoreFrags;
      send_header(seal_header(h));
      // Second protocol slot, then an unregistered protocol.
      h = base_header(); h.ttl_proto = {8'd1, c.proto_slot_b};
      send_header(seal_header(h));
      h = base_header(); h.ttl_proto = 16'hFFFF;
      send_header(seal_header(h));
      // Header length field at both ends; values below five are not checked.
      h = base_header(); h.ver_ihl_tos = 16'h4000;
      send_header(seal_header(h));
      h = base_header(); h.ver_ihl_tos = 16'h4FFF;
      send_header(seal_header(h));
      // Largest datagram in a saturated buffer.
      h = base_header(); h.total_len = 16'hFFFF; h.buffer_len = 16'hFFFF;
      send_header(seal_header(h));

      // Checksum offloaded: a corrupted checksum must now pass. The unused
      // register indexes are written too and must leave nothing changed.
      c.csum_offloaded = 1'b1;
      write_config(c, 1'b1);
      h = seal_header(base_header()); h.hdr_csum = ~h.hdr_csum;
      send_header(h);
      h = base_header(); h.ttl_proto = {8'd255, c.proto_slot_b};
      h.hdr_csum = 16'h1234;
      send_header(h);

      // Random phases: all-zero registers, all-one registers, then random
      // settings. Two of the phases run without any gaps or stalls, and
      // every phase pauses once mid-way until the pipeline has emptied.
      for (phase = 0; phase < PhaseCount; phase++) begin
         case (phase)
            0: begin
               c.host_addr = '0; c.subnet_mask = '0; c.csum_offloaded = 1'b0;
               c.proto_slot_a = '0; c.proto_slot_b = '0;
            end
            1: begin
               c.host_addr = '1; c.subnet_mask = '1; c.csum_offloaded = 1'b1;
               c.proto_slot_a = '1; c.proto_slot_b = '1;
            end
            default: c = random_config();
         endcase
         write_config(c, phase == 2);
         stalls_on <= (phase != 0) && (phase != 3);
         for (n = 0; n < PhaseItems; n++) begin
            if (n == PressureAt) wait_all_verdicts();
            send_header(random_header());
         end
      end

      // Let everything outstanding arrive, then allow a few more cycles for
      // any stray result transaction to show up before the verdict.
      wait_all_verdicts();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && verdicts_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
